// ===== hw/rtl/bscm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bscm_pkg;

  // Stack geometry and ADC resolution
  localparam int NUM_TAPS = 8;
  localparam int ADC_BITS = 12;

  // Field widths fixed by the interface
  localparam int TAP_W    = 3;
  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 16;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 8;
  localparam int SCALE_W  = 24;
  localparam int FRAC_W   = 16;

  // Accumulator holds up to 256 full-scale samples
  localparam int SUM_W   = ADC_BITS + CNT_W;
  localparam int PROD_W  = SUM_W + SCALE_W;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int SAT_LSB = FRAC_W + MV_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_TAP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACK_LOW_MV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LOW_MV     = 3'd3;

  // Register reset values
  localparam logic [CNT_W-1:0]   RST_SAMPLES_PER_TAP = 8'd16;
  localparam logic [SCALE_W-1:0] RST_SCALE_Q16       = 24'd52822;
  localparam logic [MV_W-1:0]    RST_PACK_LOW_MV     = 16'd30000;
  localparam logic [MV_W-1:0]    RST_CELL_LOW_MV     = 16'd3000;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CELL_LOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PACK_LOW = 2'd2;

  // Stream payload widths (padded to whole bytes)
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 40;
  localparam int M_PAD_W  = M_DATA_W - TAP_W - 2 * MV_W - STATUS_W;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic [M_PAD_W-1:0]  pad;
    logic [STATUS_W-1:0] status;
    logic [MV_W-1:0]     pack_mv;
    logic [MV_W-1:0]     cell_mv;
    logic [TAP_W-1:0]    tap_done;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/battery_stack_cell_monitor.sv =====
// Samples that do not complete a tap are taken back to back; ready stays high meanwhile.
// A completing sample runs a restoring divide of one quotient bit per cycle (SUM_W = 20
// quotient bits), then a multiply step, a saturate step and a result step. No sample is
// taken until the sequencer is back in idle; it stays in its result state while an earlier
// result still waits on the output. Reset (rst, synchronous, active high) loads register
// defaults and clears the accumulator, tap history and output valid.
`timescale 1ns / 1ps
`default_nettype none

module battery_stack_cell_monitor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Sample stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [bscm_pkg::S_DATA_W-1:0]   s_tdata,   // tap[2:0], sample[14:3], zero pad
  // Result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [bscm_pkg::M_DATA_W-1:0]        m_tdata,   // tap_done[2:0], cell_mv[18:3],
                                                          // pack_mv[34:19], status[36:35], pad
  output logic                                 m_tlast,
  // Configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bscm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bscm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [bscm_pkg::SUM_W-1:0] SMP_MASK =
    bscm_pkg::SUM_W'((64'd1 << bscm_pkg::ADC_BITS) - 64'd1);

  // Configuration registers
  logic [bscm_pkg::CNT_W-1:0]   samples_per_tap;
  logic [bscm_pkg::SCALE_W-1:0] scale_q16;
  logic [bscm_pkg::MV_W-1:0]    pack_low_mv;
  logic [bscm_pkg::MV_W-1:0]    cell_low_mv;

  // Running state
  bscm_pkg::state_t             state, state_next;
  logic [bscm_pkg::SUM_W-1:0]   sample_sum;
  logic [bscm_pkg::CNT_W-1:0]   sample_count;
  logic [bscm_pkg::MV_W-1:0]    prev_tap_mv;
  logic                         cell_low_seen;

  // Divider and datapath registers
  logic [bscm_pkg::STEP_W-1:0]  step;
  logic [bscm_pkg::CNT_W-1:0]   div_q;
  logic [bscm_pkg::CNT_W-1:0]   rem_q;
  logic [bscm_pkg::SUM_W-1:0]   quo_q;
  logic [bscm_pkg::TAP_W-1:0]   tap_q;
  logic [bscm_pkg::PROD_W-1:0]  prod_q;
  logic [bscm_pkg::MV_W-1:0]    mv_q;
  bscm_pkg::result_t            res_q;
  logic                         last_q;

  // Input decode
  logic [bscm_pkg::TAP_W-1:0]   in_tap;
  logic [bscm_pkg::SUM_W-1:0]   in_smp;
  logic                         in_acc;
  logic [bscm_pkg::CNT_W-1:0]   target;
  logic [bscm_pkg::CNT_W-1:0]   count_inc;
  logic [bscm_pkg::SUM_W-1:0]   sum_inc;
  logic                         tap_complete;

  assign in_tap = s_tdata[bscm_pkg::TAP_W-1:0];
  assign in_smp = bscm_pkg::SUM_W'(s_tdata[bscm_pkg::TAP_W +: bscm_pkg::SAMPLE_W]) & SMP_MASK;
  assign in_acc = s_tvalid && s_tready;

  // A zero count acts as one; an 8-bit wrap of the count also completes the tap
  assign target       = (samples_per_tap == '0) ? bscm_pkg::CNT_W'(1) : samples_per_tap;
  assign count_inc    = sample_count + bscm_pkg::CNT_W'(1);
  assign sum_inc      = sample_sum + in_smp;
  assign tap_complete = (count_inc == '0) || (count_inc >= target);

  // Restoring divide step
  logic [bscm_pkg::CNT_W:0]     div_shift;
  logic [bscm_pkg::CNT_W+1:0]   div_diff;
  logic                         div_ge;

  assign div_shift = {rem_q, quo_q[bscm_pkg::SUM_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_q};
  assign div_ge    = !div_diff[bscm_pkg::CNT_W+1];

  // Result computation
  logic [bscm_pkg::MV_W-1:0]     prev_mv;
  logic [bscm_pkg::MV_W-1:0]     cell_mv;
  logic                          cell_low;
  logic                          seen_new;
  logic                          is_last;
  logic [bscm_pkg::STATUS_W-1:0] status_new;
  logic                          out_free;

  assign prev_mv  = (tap_q == '0) ? '0 : prev_tap_mv;
  assign cell_mv  = mv_q - prev_mv;
  assign cell_low = (cell_mv <= cell_low_mv);
  assign seen_new = (tap_q == '0) ? cell_low : (cell_low_seen || cell_low);
  assign is_last  = (32'(tap_q) == 32'(bscm_pkg::NUM_TAPS - 1));
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (mv_q <= pack_low_mv) begin
      status_new = bscm_pkg::STATUS_PACK_LOW;
    end else if (seen_new) begin
      status_new = bscm_pkg::STATUS_CELL_LOW;
    end else begin
      status_new = bscm_pkg::STATUS_OK;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bscm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      bscm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && tap_complete) begin
          state_next = bscm_pkg::ST_DIV;
        end
      end
      bscm_pkg::ST_DIV: begin
        if (step == bscm_pkg::STEP_W'(bscm_pkg::SUM_W - 1)) begin
          state_next = bscm_pkg::ST_MUL;
        end
      end
      bscm_pkg::ST_MUL: state_next = bscm_pkg::ST_SAT;
      bscm_pkg::ST_SAT: state_next = bscm_pkg::ST_FIN;
      bscm_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = bscm_pkg::ST_IDLE;
        end
      end
      default: state_next = bscm_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers; writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_tap <= bscm_pkg::RST_SAMPLES_PER_TAP;
      scale_q16       <= bscm_pkg::RST_SCALE_Q16;
      pack_low_mv     <= bscm_pkg::RST_PACK_LOW_MV;
      cell_low_mv     <= bscm_pkg::RST_CELL_LOW_MV;
    end else if (cfg_valid) begin
      case (cfg_index)
        bscm_pkg::CFG_SAMPLES_PER_TAP: samples_per_tap <= cfg_data[bscm_pkg::CNT_W-1:0];
        bscm_pkg::CFG_SCALE_Q16:       scale_q16       <= cfg_data[bscm_pkg::SCALE_W-1:0];
        bscm_pkg::CFG_PACK_LOW_MV:     pack_low_mv     <= cfg_data[bscm_pkg::MV_W-1:0];
        bscm_pkg::CFG_CELL_LOW_MV:     cell_low_mv     <= cfg_data[bscm_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Accumulator, tap history and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      sample_count  <= '0;
      prev_tap_mv   <= '0;
      cell_low_seen <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (in_acc) begin
        if (tap_complete) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_inc;
          sample_count <= count_inc;
        end
      end
      if (state == bscm_pkg::ST_FIN && out_free) begin
        m_tvalid      <= 1'b1;
        prev_tap_mv   <= mv_q;
        cell_low_seen <= is_last ? 1'b0 : seen_new;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Divider, multiplier and result payload
  always_ff @(posedge clk) begin
    case (state)
      bscm_pkg::ST_IDLE: begin
        if (in_acc && tap_complete) begin
          quo_q <= sum_inc;
          div_q <= target;
          rem_q <= '0;
          step  <= '0;
          tap_q <= in_tap;
        end
      end
      bscm_pkg::ST_DIV: begin
        rem_q <= div_ge ? div_diff[bscm_pkg::CNT_W-1:0] : div_shift[bscm_pkg::CNT_W-1:0];
        quo_q <= {quo_q[bscm_pkg::SUM_W-2:0], div_ge};
        step  <= step + bscm_pkg::STEP_W'(1);
      end
      bscm_pkg::ST_MUL: begin
        prod_q <= bscm_pkg::PROD_W'(quo_q) * bscm_pkg::PROD_W'(scale_q16);
      end
      bscm_pkg::ST_SAT: begin
        if (prod_q[bscm_pkg::PROD_W-1:bscm_pkg::SAT_LSB] != '0) begin
          mv_q <= '1;
        end else begin
          mv_q <= prod_q[bscm_pkg::SAT_LSB-1:bscm_pkg::FRAC_W];
        end
      end
      bscm_pkg::ST_FIN: begin
        if (out_free) begin
          res_q.pad      <= '0;
          res_q.tap_done <= tap_q;
          res_q.cell_mv  <= cell_mv;
          res_q.pack_mv  <= is_last ? mv_q : '0;
          res_q.status   <= is_last ? status_new : bscm_pkg::STATUS_OK;
          last_q         <= is_last;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = res_q;
  assign m_tlast = last_q;

  // Checks
  a_div_step_range: assert property (@(posedge clk) disable iff (rst)
    state == bscm_pkg::ST_DIV |-> step < bscm_pkg::STEP_W'(bscm_pkg::SUM_W))
    else $error("divider step counter out of range");

  a_complete_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && tap_complete |=> state == bscm_pkg::ST_DIV && sample_sum == '0 &&
    sample_count == '0)
    else $error("tap completion did not start divide and clear accumulator");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_q.status != 2'd3)
    else $error("undefined status code on result");

  a_middle_tap_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> res_q.pack_mv == '0 && res_q.status == bscm_pkg::STATUS_OK)
    else $error("pack voltage or status on a middle tap result");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    $past(in_acc && tap_complete) |-> !s_tready)
    else $error("sample taken while tap result in progress");

endmodule

`default_nettype wire

// ===== dv/battery_stack_cell_monitor_checker.sv =====
`timescale 1ns / 1ps

module battery_stack_cell_monitor_checker
  import bscm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [S_DATA_W-1:0]   s_tdata,   // tap[2:0], sample[14:3], zero pad
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [M_DATA_W-1:0]   m_tdata,   // tap_done[2:0], cell_mv[18:3],
                                                // pack_mv[34:19], status[36:35], pad
  input  wire logic                  m_tlast,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         taps_checked,
  output int                         stacks_checked
);

  typedef struct packed {
    logic [TAP_W-1:0]    tap_done;
    logic [MV_W-1:0]     cell_mv;
    logic [MV_W-1:0]     pack_mv;
    logic [STATUS_W-1:0] status;
    logic                last;
  } tap_report_t;

  // Register shadows
  logic [CNT_W-1:0]   avg_len;
  logic [SCALE_W-1:0] mv_scale;
  logic [MV_W-1:0]    pack_floor;
  logic [MV_W-1:0]    cell_floor;

  // Accumulator and stack tracking
  logic [31:0]        acc_sum;
  logic [CNT_W-1:0]   acc_cnt;
  logic [MV_W-1:0]    below_mv;
  logic               low_seen;

  tap_report_t due_reports[$];
  int err_cnt   = 0;
  int tap_cnt   = 0;
  int stack_cnt = 0;

  // Accumulate one sample; returns 1 with the report when a tap completes
  function automatic bit next_tap_report(input logic [TAP_W-1:0] tap,
                                         input logic [SAMPLE_W-1:0] smp,
                                         output tap_report_t rep);
    int unsigned    target;
    int unsigned    avg;
    logic [63:0]    prod;
    logic [MV_W-1:0] mv;
    logic [MV_W-1:0] cell_diff;
    logic           low;
    rep = '0;
    acc_sum += 32'(smp);
    acc_cnt += 1'b1;
    // zero count behaves as one
    target = (avg_len == '0) ? 1 : int'(avg_len);
    if (acc_cnt != '0 && acc_cnt < target) return 1'b0;
    avg     = acc_sum / target;
    acc_sum = '0;
    acc_cnt = '0;
    prod = (64'(avg) * 64'(mv_scale)) >> FRAC_W;
    mv   = (prod > 64'hFFFF) ? '1 : prod[MV_W-1:0];
    // bottom tap measures against ground
    cell_diff = mv - ((tap == '0) ? '0 : below_mv);
    below_mv  = mv;
    low       = (cell_diff <= cell_floor);
    low_seen  = (tap == '0) ? low : (low_seen | low);
    rep.tap_done = tap;
    rep.cell_mv  = cell_diff;
    if (tap == TAP_W'(NUM_TAPS - 1)) begin
      rep.last    = 1'b1;
      rep.pack_mv = mv;
      if (mv <= pack_floor) begin
        rep.status = STATUS_PACK_LOW;
      end else if (low_seen) begin
        rep.status = STATUS_CELL_LOW;
      end else begin
        rep.status = STATUS_OK;
      end
      low_seen = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Monitor all three channels
  always @(posedge clk) begin : monitor
    tap_report_t want;
    result_t     got;
    if (rst) begin
      avg_len    = RST_SAMPLES_PER_TAP;
      mv_scale   = RST_SCALE_Q16;
      pack_floor = RST_PACK_LOW_MV;
      cell_floor = RST_CELL_LOW_MV;
      acc_sum    = '0;
      acc_cnt    = '0;
      below_mv   = '0;
      low_seen   = 1'b0;
      due_reports.delete();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLES_PER_TAP: avg_len    = cfg_data[CNT_W-1:0];
          CFG_SCALE_Q16:       mv_scale   = cfg_data[SCALE_W-1:0];
          CFG_PACK_LOW_MV:     pack_floor = cfg_data[MV_W-1:0];
          CFG_CELL_LOW_MV:     cell_floor = cfg_data[MV_W-1:0];
          default: ;
        endcase
      end
      // result transaction, compared against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual tap %0d cell %0d",
                   $time, got.tap_done, got.cell_mv);
          err_cnt++;
        end else begin
          want = due_reports.pop_front();
          check_field("tap_done", want.tap_done, got.tap_done);
          check_field("cell_mv", want.cell_mv, got.cell_mv);
          check_field("pack_mv", want.pack_mv, got.pack_mv);
          check_field("status", want.status, got.status);
          check_field("last", want.last, m_tlast);
          tap_cnt++;
          if (want.last) stack_cnt++;
        end
      end
      // sample transaction
      if (s_tvalid && s_tready) begin
        if (next_tap_report(s_tdata[TAP_W-1:0], s_tdata[TAP_W +: SAMPLE_W], want)) begin
          due_reports.push_back(want);
        end
      end
    end
    pending        <= due_reports.size();
    errors         <= err_cnt;
    taps_checked   <= tap_cnt;
    stacks_checked <= stack_cnt;
  end

endmodule

// ===== dv/battery_stack_cell_monitor_tb.sv =====
`timescale 1ns / 1ps

module battery_stack_cell_monitor_tb;
  import bscm_pkg::*;

  localparam int TOTAL_ITEMS = 1450;
  localparam int DRAIN_GAP   = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT    = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_CELL_LOW_MV + 1'b1;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  wire                   s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;   // tap[2:0], sample[14:3], zero pad
  wire                   m_tvalid;
  logic                  m_tready  = 1'b0;
  wire  [M_DATA_W-1:0]   m_tdata;          // tap_done[2:0], cell_mv[18:3],
                                           // pack_mv[34:19], status[36:35], pad
  wire                   m_tlast;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic hold_start = 1'b0;
  logic calm       = 1'b0;
  int   errors, pending, taps_checked, stacks_checked;
  int   cycles        = 0;
  int   hold_left     = 0;
  int   items_sent    = 0;
  int   settings_used = 0;

  battery_stack_cell_monitor uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  battery_stack_cell_monitor_checker report_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending),
    .taps_checked   (taps_checked),
    .stacks_checked (stacks_checked)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_start && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One sample transaction, then an optional random gap
  task automatic send_sample(input logic [TAP_W-1:0] tap, input logic [SAMPLE_W-1:0] smp);
    int gaps;
    gaps = 0;
    s_tdata  <= {{(S_DATA_W - TAP_W - SAMPLE_W){1'b0}}, smp, tap};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    while (!calm && $urandom_range(99) < IDLE_PCT) gaps++;
    if (gaps > 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the selected registers back to back once the block is idle
  task automatic program_regs(input logic [CNT_W-1:0] spt, input logic [SCALE_W-1:0] scale,
                              input logic [MV_W-1:0] pack_low, input logic [MV_W-1:0] cell_low,
                              input bit [3:0] mask, input bit junk);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx[0] = CFG_SAMPLES_PER_TAP;  val[0] = CFG_DATA_W'(spt);
    idx[1] = CFG_SCALE_Q16;        val[1] = CFG_DATA_W'(scale);
    idx[2] = CFG_PACK_LOW_MV;      val[2] = CFG_DATA_W'(pack_low);
    idx[3] = CFG_CELL_LOW_MV;      val[3] = CFG_DATA_W'(cell_low);
    idx[4] = CFG_FIRST_UNUSED +
             CFG_IDX_W'($urandom_range(0, (2 ** CFG_IDX_W) - 1 - int'(CFG_FIRST_UNUSED)));
    val[4] = CFG_DATA_W'($urandom);
    wait_drained();
    repeat (DRAIN_GAP) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      if ((i < 4 && mask[i]) || (i == 4 && junk)) begin
        cfg_index <= idx[i];
        cfg_data  <= val[i];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [SAMPLE_W-1:0] probe [8];
    logic [CNT_W-1:0]    spt;
    logic [SCALE_W-1:0]  scale;
    logic [MV_W-1:0]     pack_low;
    logic [MV_W-1:0]     cell_low;
    int target, frames, kind, t, phase;

    probe = '{12'd4095, 12'd0, 12'd4095, 12'd1, 12'd2048, 12'd4095, 12'd7, 12'd4095};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero count acts as one, full scale saturates, wrap below previous tap
    program_regs('0, '1, '0, '0, 4'hF, 1'b0);
    for (int i = 0; i < NUM_TAPS; i++) send_sample(TAP_W'(i), probe[i]);

    // Every cell low, middle taps skipped
    program_regs('0, RST_SCALE_Q16, '0, '1, 4'b1010, 1'b0);
    send_sample(TAP_W'(0), 12'd3000);
    send_sample(TAP_W'(3), 12'd1000);
    send_sample(TAP_W'(NUM_TAPS - 1), 12'd4000);

    // Pack low wins over cell low
    program_regs('0, '0, '1, '0, 4'b0100, 1'b0);
    send_sample(TAP_W'(0), 12'd100);
    send_sample(TAP_W'(NUM_TAPS - 1), 12'd4095);

    // Mixed tags in one average, then count lowered mid-tap
    program_regs(8'd4, '0, RST_PACK_LOW_MV, RST_CELL_LOW_MV, 4'b1101, 1'b0);
    send_sample(TAP_W'(2), 12'd4095);
    send_sample(TAP_W'(5), 12'd123);
    send_sample(TAP_W'(1), 12'd2000);
    program_regs(8'd2, '0, '0, '0, 4'b0001, 1'b0);
    send_sample(TAP_W'(4), 12'd4095);

    // Zero scale, unused register index
    program_regs('0, '0, '0, '0, 4'b0010, 1'b1);
    send_sample(TAP_W'(NUM_TAPS - 1), 12'd4095);
    send_sample(TAP_W'(NUM_TAPS - 1), 12'd4095);

    // Random phases, each with its own register setting
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      kind = $urandom_range(99);
      if (phase == 5)      spt = '1;
      else if (phase == 0) spt = CNT_W'($urandom_range(1, 6));
      else if (kind < 12)  spt = '0;
      else if (kind < 80)  spt = CNT_W'($urandom_range(1, 6));
      else if (kind < 96)  spt = CNT_W'($urandom_range(7, 40));
      else                 spt = CNT_W'($urandom_range(41, 255));
      case ($urandom_range(9))
        0:       scale = '0;
        1:       scale = '1;
        2, 3:    scale = SCALE_W'($urandom);
        default: scale = SCALE_W'($urandom_range(30000, 80000));
      endcase
      case ($urandom_range(9))
        0:       pack_low = '0;
        1:       pack_low = '1;
        2:       pack_low = MV_W'($urandom);
        default: pack_low = MV_W'($urandom_range(0, 20000));
      endcase
      case ($urandom_range(9))
        0:       cell_low = '0;
        1:       cell_low = '1;
        2:       cell_low = MV_W'($urandom);
        default: cell_low = MV_W'($urandom_range(0, 1500));
      endcase
      program_regs(spt, scale, pack_low, cell_low,
                   $urandom_range(1) ? 4'hF : 4'($urandom_range(1, 15)),
                   $urandom_range(9) == 0);
      calm <= (phase >= 2 && phase < 5);
      // long receiver hold-off while samples keep coming
      if (phase == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      target = (spt == '0) ? 1 : int'(spt);
      frames = $urandom_range(1, 5);
      for (int f = 0; f < frames && items_sent < TOTAL_ITEMS; f++) begin
        if (phase == 1 && f == 1) wait_drained();
        kind = $urandom_range(99);
        if (target > 40) begin
          // long averages: a single tap only
          t = $urandom_range(0, NUM_TAPS - 1);
          repeat (target) send_sample(TAP_W'(t), rand_sample());
        end else if (kind < 75) begin
          // well-formed stack scan
          for (t = 0; t < NUM_TAPS; t++) begin
            repeat (target) send_sample(TAP_W'(t), rand_sample());
          end
        end else if (kind < 90) begin
          // noise: random tags
          repeat ($urandom_range(1, 12)) send_sample(TAP_W'($urandom), rand_sample());
        end else begin
          // broken scan: skipped taps, short and long averages
          for (t = 0; t < NUM_TAPS; t++) begin
            if ($urandom_range(99) >= 20) begin
              repeat (target - 1 + $urandom_range(0, 2)) send_sample(TAP_W'(t), rand_sample());
            end
          end
        end
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_GAP) @(posedge clk);
    $display("Covered %0d samples under %0d register settings.", items_sent, settings_used);
    $display("Checked %0d tap results, %0d of them top-of-stack reports.",
             taps_checked, stacks_checked);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bscm_pkg.sv
hw/rtl/battery_stack_cell_monitor.sv
dv/battery_stack_cell_monitor_checker.sv
dv/battery_stack_cell_monitor_tb.sv
